[rtl/contour_corner_thinning_unit_assert.svh]
`ifndef CONTOUR_CORNER_THINNING_UNIT_ASSERT_SVH
`define CONTOUR_CORNER_THINNING_UNIT_ASSERT_SVH

// Implication checked in the same cycle, off while reset is high.
`define CCT_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, off while reset is high.
`define CCT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cct_pkg.sv]
package cct_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = HGT_W + 1;
  localparam int EW_W      = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(1024);
  localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(1024);

  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Window cell r*3+c: the cells around it inside the 3x3 window.
  localparam logic [8:0] NBR_MASK [9] = '{
    9'h01A, 9'h03D, 9'h032,
    9'h0D3, 9'h1EF, 9'h196,
    9'h098, 9'h178, 9'h0B0
  };

  // Control for one item on its way from the input edge to the window logic.
  typedef struct packed {
    logic             emit;
    logic             pix;
    logic             left_edge;
    logic             right_edge;
    logic             top_edge;
    logic             bot_edge;
    logic             frame_end;
    logic [COL_W-1:0] out_col;
  } s1_t;

  typedef struct packed {
    logic pixel;
    logic row_end;
    logic frame_end;
  } res_t;

endpackage

[rtl/contour_corner_thinning_unit.sv]
// Streaming corner thinning of a binary contour image.
// Input channel (in_valid/in_ready): pixel_in and drain, one pixel per item in
// raster order. A drain item acts as a background pixel; after a frame the
// source sends image_width + 1 drain items to flush the last results.
// Output channel (out_valid/out_ready): pixel_out, row_end, frame_end. One
// result item per input item once the first row and one pixel are in, so a
// result follows its pixel by image_width + 1 items.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 image_width,
// 1 image_height); the user writes only while the block is idle (unchecked).
// Timing: an accepted item reads the two line memories, the window logic works
// on it in the next cycle and its result is registered into the output queue,
// from which the receiver takes it.
// Throughput is one item per cycle unless stalled; the limit is the single
// window stage that feeds the thinned left pixel back into the next item.
// Stall: results wait in a three-entry output queue; in_ready drops when the
// queue and the item in the window stage would fill it, and rises again after
// the receiver takes an item.
// Reset: sizes return to 1024 x 1024 and all positions, the window and the
// left pixel clear. The line memories are not cleared: border masking hides
// their stale entries, so no clearing pass holds back items after reset.
`include "contour_corner_thinning_unit_assert.svh"
module contour_corner_thinning_unit import cct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 pixel_in,
  input  logic                 drain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 pixel_out,
  output logic                 row_end,
  output logic                 frame_end
);

  function automatic logic must_clear(input logic [8:0] g);
    logic [8:0] nb;
    logic       vert;
    logic       horiz;
    logic       lonely;
    nb     = g;
    nb[4]  = 1'b0;
    vert   = nb[1] | nb[7];
    horiz  = nb[3] | nb[5];
    lonely = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (nb[i] && ((nb & NBR_MASK[i]) == 9'd0)) begin
        lonely = 1'b1;
      end
    end
    return vert & horiz & ~lonely;
  endfunction

  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;

  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [HGT_W-1:0] out_row;

  logic             s1_valid;
  s1_t              s1;
  logic [8:0]       window_bits;
  logic             left_thinned;
  logic             byp;
  logic             byp_bit;

  res_t                oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_head;
  logic [OQ_PTR_W-1:0] oq_tail;
  logic [OQ_CNT_W-1:0] oq_count;

  logic [EW_W-1:0]  w_ext;
  logic [EW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [COL_W-1:0] col;
  logic             col_last;
  logic             pix;
  logic             emit;
  logic [COL_W-1:0] oc;
  logic             o_row_end;
  logic             o_bot;
  logic             o_frame_end;
  logic             in_fire;

  logic [0:0]       cur_rdata;
  logic [0:0]       prev_rdata;
  logic             prev_bit;
  logic [8:0]       win_new;
  logic [2:0]       lc;
  logic [2:0]       cc;
  logic [2:0]       rc;
  logic [8:0]       g;
  logic             res;
  logic             s1_wr;
  logic             oq_push;
  logic             oq_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HGT_W-1:0];
      endcase
    end
  end

  // Position control, all settled at the input edge.
  always_comb begin
    w_ext = EW_W'(image_width);
    if (w_ext == '0) begin
      eff_w = EW_W'(1);
    end else if (w_ext > EW_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    eff_h = (image_height == '0) ? ROW_W'(1) : ROW_W'(image_height);

    col         = (EW_W'(in_col) >= eff_w) ? '0 : in_col;
    col_last    = (EW_W'(col) + EW_W'(1)) >= eff_w;
    pix         = pixel_in & ~drain & (in_row < eff_h);
    emit        = (in_row >= ROW_W'(2)) | ((in_row == ROW_W'(1)) & (col != '0));
    oc          = (EW_W'(out_col) >= eff_w) ? '0 : out_col;
    o_row_end   = (EW_W'(oc) + EW_W'(1)) >= eff_w;
    o_bot       = (ROW_W'(out_row) + ROW_W'(1)) >= eff_h;
    o_frame_end = o_row_end & o_bot;
  end

  assign in_ready = ((OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(s1_valid))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH);
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (in_fire) begin
      if (emit && o_frame_end) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_last) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= col + COL_W'(1);
        end
        priority if (!emit) begin
          out_col <= oc;
        end else if (o_row_end) begin
          out_col <= '0;
          out_row <= out_row + HGT_W'(1);
        end else begin
          out_col <= oc + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.emit       <= emit;
      s1.pix        <= pix;
      s1.left_edge  <= (oc == '0);
      s1.right_edge <= o_row_end;
      s1.top_edge   <= (out_row == '0);
      s1.bot_edge   <= o_bot;
      s1.frame_end  <= o_frame_end;
      s1.out_col    <= oc;
    end
  end

  cct_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_cur_row (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (pix),
    .raddr (col),
    .rdata (cur_rdata)
  );

  cct_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_prev_row (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1.out_col),
    .wdata (res),
    .raddr (col),
    .rdata (prev_rdata)
  );

  // Forward the thinned pixel written in the same cycle as the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= s1_wr & (s1.out_col == col);
    end
  end

  always_ff @(posedge clk) begin
    byp_bit <= res;
  end

  // Window stage.
  always_comb begin
    prev_bit = byp ? byp_bit : prev_rdata[0];
    win_new  = {s1.pix, cur_rdata[0], prev_bit, window_bits[8:3]};
    lc       = s1.left_edge  ? 3'b000 : win_new[2:0];
    cc       = win_new[5:3];
    rc       = s1.right_edge ? 3'b000 : win_new[8:6];
    g        = {rc[2], cc[2], lc[2], rc[1], cc[1], ~s1.left_edge & left_thinned,
                rc[0], cc[0], lc[0]};
    if (s1.top_edge) begin
      g[2:0] = 3'b000;
    end
    if (s1.bot_edge) begin
      g[8:6] = 3'b000;
    end
    res = g[4] & ~must_clear(g);
  end

  assign s1_wr = s1_valid & s1.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits  <= '0;
      left_thinned <= 1'b0;
    end else if (s1_valid) begin
      // Start the next frame from an empty window.
      if (s1.emit && s1.frame_end) begin
        window_bits  <= '0;
        left_thinned <= 1'b0;
      end else begin
        window_bits <= win_new;
        if (s1.emit) begin
          left_thinned <= res;
        end
      end
    end
  end

  // Output queue.
  assign oq_push   = s1_wr;
  assign oq_pop    = out_valid & out_ready;
  assign out_valid = (oq_count != '0);
  assign pixel_out = oq[oq_head].pixel;
  assign row_end   = oq[oq_head].row_end;
  assign frame_end = oq[oq_head].frame_end;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_tail] <= '{pixel: res, row_end: s1.right_edge, frame_end: s1.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head  <= '0;
      oq_tail  <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_tail <= (oq_tail == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_tail + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_head <= (oq_head == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_head + OQ_PTR_W'(1);
      end
      oq_count <= oq_count + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end
  end

  `CCT_ASSERT_NOW(a_oq_room, clk, rst, s1_valid, oq_count < OQ_CNT_W'(OQ_DEPTH), "output queue full with an item in flight")
  `CCT_ASSERT_NOW(a_frame_on_row, clk, rst, out_valid && frame_end, row_end, "frame end away from a row end")
  `CCT_ASSERT_NEXT(a_restart, clk, rst, in_fire && emit && o_frame_end, in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0, "positions not cleared after frame end")

endmodule

[rtl/cct_ram.sv]
module cct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
